/* design/gcc_pkg.sv */
// Shared constants and types for the grid coin collecting block.
package gcc_pkg;

  // Beat payload widths
  localparam int COIN_W      = 8;
  localparam int OUT_TOTAL_W = 20;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 2;

  // Row counting
  localparam int ROW_W     = 10;
  localparam int ROW_LIMIT = 1024;

  // Defaults for top-level parameters
  localparam int MAX_COLS_DEF   = 1024;
  localparam int TOTAL_BITS_DEF = 20;

  // Grid size after reset
  localparam logic [CFG_DATA_W-1:0] GRID_DIM_RST = CFG_DATA_W'(16);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 2'd0,
    CFG_GRID_COLS = 2'd1
  } cfg_reg_e;

  // Position flags of a cell, passed from the counters to the cell stage
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last;
  } pos_flags_t;

endpackage

/* design/gcc_in_if.sv */
// Input cell channel: coin amount and obstacle flag.
interface gcc_in_if;
  logic                       valid;
  logic                       ready;
  logic [gcc_pkg::COIN_W-1:0] coin_amount;
  logic                       blocked;

  modport source (output valid, coin_amount, blocked, input ready);
  modport sink   (input valid, coin_amount, blocked, output ready);
endinterface

/* design/gcc_out_if.sv */
// Result channel: best path total, reachability and last-cell mark.
interface gcc_out_if;
  logic                            valid;
  logic                            ready;
  logic [gcc_pkg::OUT_TOTAL_W-1:0] path_total;
  logic                            reachable;
  logic                            last_cell;

  modport source (output valid, path_total, reachable, last_cell, input ready);
  modport sink   (input valid, path_total, reachable, last_cell, output ready);
endinterface

/* design/gcc_cfg_if.sv */
// Configuration write channel: register index and write data.
interface gcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gcc_pkg::CFG_IDX_W-1:0]  index;
  logic [gcc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/gcc_ctrl.sv */
// Grid size registers and raster position counters.
module gcc_ctrl #(
  parameter int MaxCols = gcc_pkg::MAX_COLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           take_i,
  output logic [$clog2(MaxCols)-1:0]     col_o,
  output gcc_pkg::pos_flags_t            flags_o
);

  localparam int AddrW = $clog2(MaxCols);
  localparam int CntW  = $clog2(MaxCols + 1);
  localparam int RowCntW = gcc_pkg::ROW_W + 1;

  logic [gcc_pkg::CFG_DATA_W-1:0] rows_q, cols_q;
  logic [AddrW-1:0]               col_q, col_d;
  logic [gcc_pkg::ROW_W-1:0]      row_q, row_d;
  logic [CntW-1:0]                cols_eff;
  logic [RowCntW-1:0]             rows_eff;
  logic                           col_end, row_end;

  // Effective bounds: zero means one, too large is clamped
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = CntW'(1);
    end else if (32'(cols_q) > 32'(MaxCols)) begin
      cols_eff = CntW'(MaxCols);
    end else begin
      cols_eff = CntW'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = RowCntW'(1);
    end else if (32'(rows_q) > 32'(gcc_pkg::ROW_LIMIT)) begin
      rows_eff = RowCntW'(gcc_pkg::ROW_LIMIT);
    end else begin
      rows_eff = RowCntW'(rows_q);
    end
  end

  assign col_end = (CntW'(col_q) == cols_eff - CntW'(1));
  assign row_end = (RowCntW'(row_q) == rows_eff - RowCntW'(1));

  // Next raster position, wrapping at row and grid end
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + gcc_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
    end
  end

  // Writes to grid_rows or grid_cols restart the grid at the origin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gcc_pkg::GRID_DIM_RST;
      cols_q <= gcc_pkg::GRID_DIM_RST;
      col_q  <= '0;
      row_q  <= '0;
    end else if (cfg_we_i) begin
      case (gcc_pkg::cfg_reg_e'(cfg_idx_i))
        gcc_pkg::CFG_GRID_ROWS: begin
          rows_q <= cfg_data_i;
          col_q  <= '0;
          row_q  <= '0;
        end
        gcc_pkg::CFG_GRID_COLS: begin
          cols_q <= cfg_data_i;
          col_q  <= '0;
          row_q  <= '0;
        end
        default: ;
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o             = col_q;
  assign flags_o.first_row = (row_q == '0);
  assign flags_o.first_col = (col_q == '0);
  assign flags_o.last      = row_end && col_end;

endmodule

/* design/gcc_linebuf.sv */
// Line buffer holding the previous row's totals, with write-to-read bypass.
module gcc_linebuf #(
  parameter int MaxCols = gcc_pkg::MAX_COLS_DEF,
  parameter int Width   = gcc_pkg::TOTAL_BITS_DEF + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(MaxCols)-1:0] rd_addr_i,
  output logic [Width-1:0]           rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(MaxCols)-1:0] wr_addr_i,
  input  logic [Width-1:0]           wr_data_i
);

  logic [Width-1:0] mem_q [MaxCols];
  logic [Width-1:0] rd_data_q;
  logic [Width-1:0] byp_data_q;
  logic             byp_q;

  // Storage: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // A read colliding with a same-cycle write takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_data_q;

endmodule

/* design/gcc_cell.sv */
// Cell stage: input register, best-predecessor add with saturation, result register.
module gcc_cell #(
  parameter int MaxCols   = gcc_pkg::MAX_COLS_DEF,
  parameter int TotalBits = gcc_pkg::TOTAL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input beat
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gcc_pkg::COIN_W-1:0]      coin_i,
  input  logic                            blocked_i,
  input  logic [$clog2(MaxCols)-1:0]      col_i,
  input  gcc_pkg::pos_flags_t             flags_i,
  // Line buffer
  input  logic [TotalBits:0]              above_i,
  output logic                            wr_en_o,
  output logic [$clog2(MaxCols)-1:0]      wr_addr_o,
  output logic [TotalBits:0]              wr_data_o,
  // Result beat
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gcc_pkg::OUT_TOTAL_W-1:0] path_total_o,
  output logic                            reachable_o,
  output logic                            last_cell_o
);

  localparam int AddrW = $clog2(MaxCols);

  logic                       s1_valid_q;
  logic [gcc_pkg::COIN_W-1:0] coin_q;
  logic                       blocked_q;
  logic [AddrW-1:0]           col_q;
  gcc_pkg::pos_flags_t        flags_q;

  logic [TotalBits-1:0] left_q;
  logic                 left_ok_q;

  logic                       out_valid_q;
  logic [gcc_pkg::OUT_TOTAL_W-1:0] total_q;
  logic                       ok_q, last_q;

  logic                 fire, take;
  logic                 above_ok, left_use, ok;
  logic [TotalBits-1:0] above_tot, base, best;
  logic [TotalBits:0]   sum;

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;
  assign take       = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      coin_q    <= coin_i;
      blocked_q <= blocked_i;
      col_q     <= col_i;
      flags_q   <= flags_i;
    end
  end

  // Pick the better reachable predecessor, add coins, saturate
  assign above_tot = above_i[TotalBits-1:0];
  assign above_ok  = !flags_q.first_row && above_i[TotalBits];
  assign left_use  = !flags_q.first_col && left_ok_q;

  always_comb begin
    base = '0;
    ok   = 1'b0;
    if (!blocked_q) begin
      if (flags_q.first_row && flags_q.first_col) begin
        ok = 1'b1;
      end else if (above_ok && left_use) begin
        ok   = 1'b1;
        base = (left_q > above_tot) ? left_q : above_tot;
      end else if (above_ok) begin
        ok   = 1'b1;
        base = above_tot;
      end else if (left_use) begin
        ok   = 1'b1;
        base = left_q;
      end
    end
    sum  = {1'b0, base} + (TotalBits + 1)'(coin_q);
    best = sum[TotalBits] ? '1 : sum[TotalBits-1:0];
    if (!ok) begin
      best = '0;
    end
  end

  assign wr_en_o   = fire;
  assign wr_addr_o = col_q;
  assign wr_data_o = {ok, best};

  // Left neighbor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_ok_q <= 1'b0;
    end else if (fire) begin
      left_ok_q <= ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      left_q <= best;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      total_q <= gcc_pkg::OUT_TOTAL_W'(best);
      ok_q    <= ok;
      last_q  <= flags_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign path_total_o = total_q;
  assign reachable_o  = ok_q;
  assign last_cell_o  = last_q;

endmodule

/* design/grid_coin_collect_dp.sv */
// Grid coin collecting block: best right/down path total per cell, with obstacles.
//
// Cells arrive in raster order, top-left first, one beat per cell, and each
// cell gives exactly one result beat: the best coin total over right/down
// paths from the origin (saturating at 2^TOTAL_BITS-1, shown in 20 bits), a
// reachable flag, and a mark on the bottom-right cell. The block takes one
// cell every clock cycle unless an unaccepted result stalls it; each cell
// passes the input register, where the line buffer is read, then the result
// register. The line buffer is one MAX_COLS-deep memory with one read and
// one write port, read at the column of the incoming cell. Writing
// grid_rows or grid_cols restarts the grid at the origin; zero is taken as
// one, and sizes above 1024 rows or MAX_COLS columns are clamped. After the
// last cell the next beat starts a new grid.
module grid_coin_collect_dp #(
  parameter int MAX_COLS   = gcc_pkg::MAX_COLS_DEF,
  parameter int TOTAL_BITS = gcc_pkg::TOTAL_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gcc_cfg_if.sink       cfg_i,
  gcc_in_if.sink        in_i,
  gcc_out_if.source     out_o
);

  localparam int AddrW = $clog2(MAX_COLS);

  logic                  take;
  logic                  in_ready;
  logic [AddrW-1:0]      col;
  gcc_pkg::pos_flags_t   flags;
  logic [TOTAL_BITS:0]   above;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [TOTAL_BITS:0]   wr_data;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign take        = in_i.valid && in_ready;

  // Position counters and grid size
  gcc_ctrl #(
    .MaxCols (MAX_COLS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .take_i     (take),
    .col_o      (col),
    .flags_o    (flags)
  );

  // Previous row totals
  gcc_linebuf #(
    .MaxCols (MAX_COLS),
    .Width   (TOTAL_BITS + 1)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take),
    .rd_addr_i (col),
    .rd_data_o (above),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Cell computation and result register
  gcc_cell #(
    .MaxCols   (MAX_COLS),
    .TotalBits (TOTAL_BITS)
  ) u_cell (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_ready),
    .coin_i       (in_i.coin_amount),
    .blocked_i    (in_i.blocked),
    .col_i        (col),
    .flags_i      (flags),
    .above_i      (above),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .path_total_o (out_o.path_total),
    .reachable_o  (out_o.reachable),
    .last_cell_o  (out_o.last_cell)
  );

endmodule
